/* design/wwfd_pkg.sv */
// Package for the weight word to float decoder: encoding and register codes,
// the unrounded float type and the single-precision helper functions.
// No dependencies.
package wwfd_pkg;

  typedef enum logic [1:0] {
    ENC_LINEAR16 = 2'd0,
    ENC_HALF     = 2'd1,
    ENC_BF16     = 2'd2,
    ENC_SINGLE   = 2'd3
  } enc_e;

  typedef enum logic [1:0] {
    REG_ENCODING  = 2'd0,
    REG_RANGE_MIN = 2'd1,
    REG_RANGE_MAX = 2'd2
  } reg_e;

  localparam logic [31:0] QNAN     = 32'h7FC0_0000;
  localparam logic [31:0] ONE      = 32'h3F80_0000;
  localparam logic [15:0] LIN_FULL = 16'hFFFF;

  // Unrounded value: mag * 2^(ex - 174); mag[0] may carry a sticky bit.
  // When mag[47] is set, mag[47:24] is the 24-bit significand at exponent ex.
  typedef struct packed {
    logic               nan;
    logic               inf;
    logic               sign;
    logic signed [10:0] ex;
    logic [47:0]        mag;
  } unr_t;

  function automatic logic [5:0] lzc48(logic [47:0] v);
    logic [5:0] n;
    n = 6'd48;
    for (int i = 0; i < 48; i++) begin
      if (v[i]) n = 6'(47 - i);
    end
    return n;
  endfunction

  // Right shift that ORs every bit shifted out into the lowest bit.
  function automatic logic [47:0] shr_sticky(logic [47:0] v, logic [5:0] sh);
    logic [47:0] mask;
    logic        st;
    mask = (sh >= 6'd48) ? '1 : ((48'd1 << sh) - 48'd1);
    st   = |(v & mask);
    return (v >> sh) | {47'd0, st};
  endfunction

  // Multiplier front end: exact 48-bit product of the significands.
  function automatic unr_t fmul_pre(logic [31:0] x, logic [31:0] y);
    logic [7:0]  ex8, ey8;
    logic [23:0] sx, sy;
    logic        nx, ny, ix, iy, zx, zy;
    unr_t        u;
    ex8    = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
    ey8    = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
    sx     = {x[30:23] != 8'd0, x[22:0]};
    sy     = {y[30:23] != 8'd0, y[22:0]};
    nx     = (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
    ny     = (y[30:23] == 8'hFF) && (y[22:0] != 23'd0);
    ix     = (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
    iy     = (y[30:23] == 8'hFF) && (y[22:0] == 23'd0);
    zx     = (x[30:0] == 31'd0);
    zy     = (y[30:0] == 31'd0);
    u.nan  = nx | ny | (ix & zy) | (iy & zx);
    u.inf  = ix | iy;
    u.sign = x[31] ^ y[31];
    u.ex   = $signed({3'b000, ex8}) + $signed({3'b000, ey8}) - 11'sd126;
    u.mag  = 48'(sx) * 48'(sy);
    return u;
  endfunction

  // Adder front end: align the smaller operand and add or subtract.
  function automatic unr_t fadd_pre(logic [31:0] x, logic [31:0] y);
    logic [7:0]  ex8, ey8, eb, es, d;
    logic [23:0] sx, sy, sgb_sig, sgs_sig;
    logic        nx, ny, ix, iy, swap, sgb, sgs;
    logic [5:0]  sh;
    logic [47:0] ma, mb;
    logic [48:0] diff;
    unr_t        u;
    ex8     = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
    ey8     = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
    sx      = {x[30:23] != 8'd0, x[22:0]};
    sy      = {y[30:23] != 8'd0, y[22:0]};
    nx      = (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
    ny      = (y[30:23] == 8'hFF) && (y[22:0] != 23'd0);
    ix      = (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
    iy      = (y[30:23] == 8'hFF) && (y[22:0] == 23'd0);
    swap    = ey8 > ex8;
    eb      = swap ? ey8 : ex8;
    es      = swap ? ex8 : ey8;
    sgb_sig = swap ? sy : sx;
    sgs_sig = swap ? sx : sy;
    sgb     = swap ? y[31] : x[31];
    sgs     = swap ? x[31] : y[31];
    d       = eb - es;
    sh      = (d > 8'd63) ? 6'd63 : d[5:0];
    ma      = {1'b0, sgb_sig, 23'd0};
    mb      = shr_sticky({1'b0, sgs_sig, 23'd0}, sh);
    diff    = {1'b0, ma} - {1'b0, mb};
    if (sgb == sgs) begin
      u.mag  = ma + mb;
      u.sign = sgb;
    end else if (diff[48]) begin
      u.mag  = mb - ma;
      u.sign = sgs;
    end else begin
      u.mag  = diff[47:0];
      u.sign = sgb;
    end
    // An exact zero is negative only when both operands are negative.
    if (u.mag == 48'd0) u.sign = x[31] & y[31];
    u.nan = nx | ny | (ix & iy & (x[31] != y[31]));
    u.inf = ix | iy;
    if (u.inf) u.sign = ix ? x[31] : y[31];
    u.ex = $signed({3'b000, eb}) + 11'sd1;
    return u;
  endfunction

  // Normalize so mag[47] is set, or denormalize to the minimum exponent.
  function automatic unr_t fnorm(unr_t u);
    logic [5:0]         lz, sh;
    logic signed [10:0] e2, shv;
    unr_t               r;
    r     = u;
    lz    = lzc48(u.mag);
    r.mag = u.mag << lz;
    e2    = u.ex - $signed({5'b00000, lz});
    shv   = 11'sd1 - e2;
    if (e2 < 11'sd1) begin
      sh    = (shv > 11'sd63) ? 6'd63 : shv[5:0];
      r.mag = shr_sticky(r.mag, sh);
      e2    = 11'sd1;
    end
    r.ex = e2;
    return r;
  endfunction

  // Round to nearest even and pack; any NaN comes out as the quiet NaN.
  function automatic logic [31:0] fround(unr_t u);
    logic [23:0]        m;
    logic               g, st, up;
    logic [24:0]        ms;
    logic signed [10:0] e3;
    m  = u.mag[47:24];
    g  = u.mag[23];
    st = |u.mag[22:0];
    up = g & (st | m[0]);
    ms = {1'b0, m} + {24'd0, up};
    e3 = u.ex;
    if (ms[24]) begin
      m  = ms[24:1];
      e3 = e3 + 11'sd1;
    end else begin
      m = ms[23:0];
    end
    if (u.nan) return QNAN;
    if (u.inf || (e3 >= 11'sd255)) return {u.sign, 8'hFF, 23'd0};
    return {u.sign, (m[23] ? e3[7:0] : 8'd0), m[22:0]};
  endfunction

  // r / 65535 is the binary fraction 0.rrrr... with r repeating, so the
  // tail is never zero except at the ends of the range: sticky is always set.
  function automatic logic [31:0] lin_t(logic [15:0] r);
    logic [3:0]  lz;
    logic [63:0] w;
    logic [23:0] m;
    logic [24:0] ms;
    logic [7:0]  e;
    logic [22:0] frac;
    lz = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (r[i]) lz = 4'(15 - i);
    end
    w  = {r, r, r, r} << lz;
    m  = w[63:40];
    ms = {1'b0, m} + {24'd0, w[39]};
    e  = 8'd126 - {4'd0, lz};
    if (ms[24]) begin
      frac = 23'd0;
      e    = e + 8'd1;
    end else begin
      frac = ms[22:0];
    end
    if (r == 16'd0) return 32'd0;
    if (r == LIN_FULL) return ONE;
    return {1'b0, e, frac};
  endfunction

  function automatic logic [31:0] half_to_single(logic [15:0] h);
    logic [4:0]  ex5;
    logic [9:0]  man, mn;
    logic [3:0]  n, k;
    logic [15:0] tmp;
    logic [7:0]  e;
    ex5 = h[14:10];
    man = h[9:0];
    n   = 4'd10;
    for (int i = 0; i < 10; i++) begin
      if (man[i]) n = 4'(9 - i);
    end
    k   = n + 4'd1;
    tmp = {6'd0, man} << k;
    mn  = tmp[9:0];
    e   = 8'd113 - {4'd0, k};
    if (ex5 == 5'd0) begin
      if (man == 10'd0) return {h[15], 31'd0};
      return {h[15], e, mn, 13'd0};
    end
    if (ex5 == 5'h1F) return {h[15], 8'hFF, man, 13'd0};
    return {h[15], {3'b000, ex5} + 8'd112, man, 13'd0};
  endfunction

endpackage

/* design/weight_word_to_float_decoder.sv */
// Weight word to float decoder top level: pipelined conversion of stored
// weight elements into single-precision words. Depends on wwfd_pkg.
//
// Usage: write the encoding, range_min and range_max registers through the
// cfg_we_i / cfg_index_i / cfg_wdata_i port while no transaction is in
// flight. A transaction is accepted at each rising edge where start_i is high
// and busy_o is low; busy_o is always low, so one element can enter in every
// cycle. The decoded word appears on value_bits_o together with valid_o for
// exactly one cycle, and results leave in acceptance order. The latency is
// set by the linear16 path: the t = raw/65535 stage, then 1 - t (align,
// normalize, round), then min * (1 - t) (multiply, normalize, round), then
// the final sum (align, normalize, round), each step in its own registered
// stage. Half, bfloat16 and single encodings are resolved in the second
// stage and travel down a delay line to keep the latency uniform. Throughput
// is one transaction per cycle for every encoding. The receiver cannot
// stall, so no back-pressure exists. Reset clears the stage valid bits and
// the configuration registers (linear16, range zero); in-flight data is
// dropped.
module weight_word_to_float_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [31:0] raw_element_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  output logic        valid_o,
  output logic [31:0] value_bits_o
);

  localparam int unsigned NStg = 11;
  localparam int unsigned NDir = 9;
  localparam int unsigned NB   = 4;

  // Configuration registers.
  wwfd_pkg::enc_e encoding_q;
  logic [31:0]    range_min_q, range_max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      encoding_q  <= wwfd_pkg::ENC_LINEAR16;
      range_min_q <= 32'd0;
      range_max_q <= 32'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        wwfd_pkg::REG_ENCODING:  encoding_q  <= wwfd_pkg::enc_e'(cfg_wdata_i[1:0]);
        wwfd_pkg::REG_RANGE_MIN: range_min_q <= cfg_wdata_i;
        wwfd_pkg::REG_RANGE_MAX: range_max_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // The pipeline never refuses a transaction.
  assign busy_o = 1'b0;

  // Stage valid bits: v_q[k] qualifies the stage k registers.
  logic [NStg-1:0] v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[NStg-2:0], start_i & ~busy_o};
    end
  end

  // Payload registers, stage by stage.
  logic [31:0]    word_q;                  // stage 0
  logic [31:0]    t_q;                     // stage 1
  logic [31:0]    dir_d;
  logic [31:0]    dir_q [NDir];            // stages 1 to 9
  wwfd_pkg::unr_t sub_a_q, mb_a_q;         // stage 2
  wwfd_pkg::unr_t sub_n_q, mb_n_q;         // stage 3
  logic [31:0]    omt_q;                   // stage 4
  logic [31:0]    b_q [NB];                // stages 4 to 7
  wwfd_pkg::unr_t ma_a_q;                  // stage 5
  wwfd_pkg::unr_t ma_n_q;                  // stage 6
  logic [31:0]    a_q;                     // stage 7
  wwfd_pkg::unr_t add_a_q;                 // stage 8
  wwfd_pkg::unr_t add_n_q;                 // stage 9
  logic [31:0]    value_bits_d, value_bits_q;  // stage 10

  // The formats that need no arithmetic are settled once the word is in.
  always_comb begin
    unique case (encoding_q)
      wwfd_pkg::ENC_HALF:   dir_d = wwfd_pkg::half_to_single(word_q[15:0]);
      wwfd_pkg::ENC_BF16:   dir_d = {word_q[15:0], 16'd0};
      wwfd_pkg::ENC_SINGLE: dir_d = word_q;
      default:              dir_d = 32'd0;
    endcase
  end

  always_comb begin
    unique case (encoding_q)
      wwfd_pkg::ENC_LINEAR16: value_bits_d = wwfd_pkg::fround(add_n_q);
      default:                value_bits_d = dir_q[NDir-1];
    endcase
  end

  always_ff @(posedge clk_i) begin
    word_q   <= raw_element_i;
    // t = r / 65535, correctly rounded.
    t_q      <= wwfd_pkg::lin_t(word_q[15:0]);
    dir_q[0] <= dir_d;
    for (int i = 1; i < NDir; i++) dir_q[i] <= dir_q[i-1];
    // 1 - t, with max * t running alongside.
    sub_a_q  <= wwfd_pkg::fadd_pre(wwfd_pkg::ONE, {~t_q[31], t_q[30:0]});
    mb_a_q   <= wwfd_pkg::fmul_pre(range_max_q, t_q);
    sub_n_q  <= wwfd_pkg::fnorm(sub_a_q);
    mb_n_q   <= wwfd_pkg::fnorm(mb_a_q);
    omt_q    <= wwfd_pkg::fround(sub_n_q);
    b_q[0]   <= wwfd_pkg::fround(mb_n_q);
    for (int i = 1; i < NB; i++) b_q[i] <= b_q[i-1];
    // min * (1 - t).
    ma_a_q   <= wwfd_pkg::fmul_pre(range_min_q, omt_q);
    ma_n_q   <= wwfd_pkg::fnorm(ma_a_q);
    a_q      <= wwfd_pkg::fround(ma_n_q);
    // a + b, then the format select.
    add_a_q  <= wwfd_pkg::fadd_pre(a_q, b_q[NB-1]);
    add_n_q  <= wwfd_pkg::fnorm(add_a_q);
    value_bits_q <= value_bits_d;
  end

  assign valid_o      = v_q[NStg-1];
  assign value_bits_o = value_bits_q;

  // Every accepted transaction yields exactly one strobe, a fixed time later.
  a_accept_to_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##11 valid_o)
    else $error("accepted transaction produced no result");

  a_result_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start_i && !busy_o, 11))
    else $error("result strobe without an accepted transaction");

  // The final sum leaves the normalizer normalized, exactly zero, or at the
  // minimum exponent.
  a_sum_normalized: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[9] |-> (add_n_q.mag[47] || (add_n_q.mag == 48'd0) || (add_n_q.ex == 11'sd1)))
    else $error("final sum not normalized before rounding");

endmodule

/* tb/tb_weight_word_to_float_decoder.sv */
// Self-checking testbench for weight_word_to_float_decoder: a queue-fed driver,
// a monitor and a bit-exact single-precision predictor of every encoding.
// Depends on wwfd_pkg and the decoder RTL.
module tb_weight_word_to_float_decoder;

  typedef struct {
    logic [23:0] sig;
    int          e;
  } fp_parts_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        start_i       = 1'b0;
  logic [31:0] raw_element_i = 32'd0;
  logic        cfg_we_i      = 1'b0;
  logic [1:0]  cfg_index_i   = 2'd0;
  logic [31:0] cfg_wdata_i   = 32'd0;
  logic        busy_o;
  logic        valid_o;
  logic [31:0] value_bits_o;

  // Configuration as the decoder should currently see it; reset values.
  wwfd_pkg::enc_e cur_encoding  = wwfd_pkg::ENC_LINEAR16;
  logic [31:0]    cur_range_min = 32'd0;
  logic [31:0]    cur_range_max = 32'd0;

  logic [31:0] pending_words[$];
  logic [31:0] expected_values[$];
  int          errors = 0;
  int          cycles = 0;
  int          gap    = 0;
  bit          quiet  = 1'b0;

  weight_word_to_float_decoder DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .raw_element_i (raw_element_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .valid_o       (valid_o),
    .value_bits_o  (value_bits_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit is_nan(logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
  endfunction

  function automatic bit is_inf(logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
  endfunction

  // Splits a finite float into an integer significand and the weight of its
  // lowest bit. Subnormals share the weight of the smallest normal.
  function automatic fp_parts_t fp_split(logic [31:0] x);
    fp_parts_t p;
    if (x[30:23] == 8'd0) begin
      p.sig = {1'b0, x[22:0]};
      p.e   = -149;
    end else begin
      p.sig = {1'b1, x[22:0]};
      p.e   = int'(x[30:23]) - 150;
    end
    return p;
  endfunction

  // Rounds the exact value (m + a fraction flagged by sticky_in) * 2^e to the
  // nearest single-precision value, ties to even, with subnormals and overflow.
  function automatic logic [31:0] fp_round(logic sgn, int e, logic [127:0] m,
                                           bit sticky_in);
    int           p, q, s;
    logic [127:0] keep;
    bit           g, st, up;
    if (m == 128'd0) return {sgn, 31'd0};
    p = 127;
    while (!m[p]) p--;
    q = e + p - 23;
    if (q < -149) q = -149;
    s = q - e;
    if (s <= 0) begin
      keep = m << (-s);
      g    = 1'b0;
      st   = sticky_in;
    end else if (s > 127) begin
      keep = 128'd0;
      g    = 1'b0;
      st   = 1'b1;
    end else begin
      keep = m >> s;
      g    = m[s-1];
      st   = ((m & ((128'd1 << (s - 1)) - 128'd1)) != 128'd0) || sticky_in;
    end
    up   = g & (st | keep[0]);
    keep = keep + 128'(up);
    if (keep[24]) begin
      keep = keep >> 1;
      q++;
    end
    if (keep[23]) begin
      if (q + 150 >= 255) return {sgn, 8'hFF, 23'd0};
      return {sgn, 8'(q + 150), keep[22:0]};
    end
    return {sgn, 8'd0, keep[22:0]};
  endfunction

  function automatic logic [31:0] fp_mul(logic [31:0] x, logic [31:0] y);
    fp_parts_t a, b;
    logic      sgn;
    sgn = x[31] ^ y[31];
    if (is_nan(x) || is_nan(y) || (is_inf(x) && y[30:0] == 31'd0) ||
        (is_inf(y) && x[30:0] == 31'd0)) return wwfd_pkg::QNAN;
    if (is_inf(x) || is_inf(y)) return {sgn, 8'hFF, 23'd0};
    a = fp_split(x);
    b = fp_split(y);
    return fp_round(sgn, a.e + b.e, 128'(a.sig) * 128'(b.sig), 1'b0);
  endfunction

  function automatic logic [31:0] fp_add(logic [31:0] x, logic [31:0] y);
    fp_parts_t    a, b, t;
    logic         sa, sb, ts;
    logic [127:0] big, tiny;
    int           d, e;
    if (is_nan(x) || is_nan(y)) return wwfd_pkg::QNAN;
    if (is_inf(x) && is_inf(y) && (x[31] != y[31])) return wwfd_pkg::QNAN;
    if (is_inf(x)) return x;
    if (is_inf(y)) return y;
    a  = fp_split(x);
    b  = fp_split(y);
    sa = x[31];
    sb = y[31];
    if (a.e < b.e) begin
      t = a; a = b; b = t;
      ts = sa; sa = sb; sb = ts;
    end
    d = a.e - b.e;
    // Far below the larger operand, the smaller one only matters as a
    // nonzero nudge that steers rounding, so a single unit stands in for it.
    if (d > 50) begin
      big  = 128'(a.sig) << 52;
      tiny = (b.sig != 24'd0) ? 128'd1 : 128'd0;
      e    = a.e - 52;
    end else begin
      big  = 128'(a.sig) << d;
      tiny = 128'(b.sig);
      e    = b.e;
    end
    if (sa == sb) return fp_round(sa, e, big + tiny, 1'b0);
    if (big > tiny) return fp_round(sa, e, big - tiny, 1'b0);
    if (tiny > big) return fp_round(sb, e, tiny - big, 1'b0);
    return {x[31] & y[31], 31'd0};
  endfunction

  // Linear16: t = r / 65535 by exact long division, then min*(1-t) + max*t
  // with every step rounded on its own.
  function automatic logic [31:0] dequantize_linear(logic [15:0] r);
    logic [63:0] num, quo;
    logic [31:0] t, one_minus_t;
    num         = 64'(r) << 48;
    quo         = num / 64'd65535;
    t           = fp_round(1'b0, -48, 128'(quo), (num % 64'd65535) != 64'd0);
    one_minus_t = fp_add(wwfd_pkg::ONE, {~t[31], t[30:0]});
    return fp_add(fp_mul(cur_range_min, one_minus_t), fp_mul(cur_range_max, t));
  endfunction

  function automatic logic [31:0] widen_half(logic [15:0] h);
    logic [31:0] sgn;
    logic [10:0] man;
    logic [7:0]  e;
    sgn = {h[15], 31'd0};
    man = {1'b0, h[9:0]};
    if (h[14:10] == 5'd0) begin
      if (man == 11'd0) return sgn;
      e = 8'd113;
      while (!man[10]) begin
        man = man << 1;
        e   = e - 8'd1;
      end
      return sgn | {1'b0, e, man[9:0], 13'd0};
    end
    if (h[14:10] == 5'h1F) return sgn | {1'b0, 8'hFF, man[9:0], 13'd0};
    return sgn | {1'b0, 8'(h[14:10]) + 8'd112, man[9:0], 13'd0};
  endfunction

  function automatic logic [31:0] decode_weight(logic [31:0] word);
    case (cur_encoding)
      wwfd_pkg::ENC_LINEAR16: return dequantize_linear(word[15:0]);
      wwfd_pkg::ENC_HALF:     return widen_half(word[15:0]);
      wwfd_pkg::ENC_BF16:     return {word[15:0], 16'd0};
      default:                return word;
    endcase
  endfunction

  // Driver: on each accepted transaction the expectation is recorded, then the
  // next element is presented unless an idle burst is running.
  always @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      expected_values.push_back(decode_weight(raw_element_i));
      if (!quiet && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 13);
    end else if (!start_i && !quiet && gap == 0 && pending_words.size() != 0 &&
                 $urandom_range(0, 15) == 0) begin
      gap = $urandom_range(1, 13);
    end
    if (gap > 0) begin
      start_i <= 1'b0;
      gap--;
    end else if (pending_words.size() != 0) begin
      start_i       <= 1'b1;
      raw_element_i <= pending_words.pop_front();
    end else begin
      start_i <= 1'b0;
    end
  end

  // Monitor: results cannot be held off, so each strobe is checked at once
  // against the oldest expectation.
  always @(posedge clk_i) begin
    if (valid_o) begin
      if (expected_values.size() == 0) begin
        $error("value_bits: expected none, got %h", value_bits_o);
        errors++;
      end else if (expected_values[0] !== value_bits_o) begin
        $error("value_bits: expected %h, got %h", expected_values[0], value_bits_o);
        errors++;
        void'(expected_values.pop_front());
      end else begin
        void'(expected_values.pop_front());
      end
    end
  end

  // Run limit: far beyond a run where every element suffers the longest gap.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 300000) begin
      $display("** weight_word_to_float_decoder: FAILED **");
      $finish;
    end
  end

  task automatic write_reg(wwfd_pkg::reg_e idx, logic [31:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    case (idx)
      wwfd_pkg::REG_ENCODING:  cur_encoding = wwfd_pkg::enc_e'(data[1:0]);
      wwfd_pkg::REG_RANGE_MIN: cur_range_min = data;
      default:                 cur_range_max = data;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_format(wwfd_pkg::enc_e enc, logic [31:0] lo, logic [31:0] hi);
    write_reg(wwfd_pkg::REG_ENCODING, {30'd0, enc});
    write_reg(wwfd_pkg::REG_RANGE_MIN, lo);
    write_reg(wwfd_pkg::REG_RANGE_MAX, hi);
  endtask

  // Waits until every transaction has left the pipeline and been checked.
  task automatic wait_idle();
    while (pending_words.size() != 0 || start_i || expected_values.size() != 0)
      @(posedge clk_i);
    repeat (14) @(posedge clk_i);
  endtask

  function automatic logic [31:0] random_range_bound();
    logic s;
    s = 1'($urandom);
    case ($urandom_range(0, 9))
      0:       return {s, 31'd0};
      1:       return {s, wwfd_pkg::ONE[30:0]};
      2:       return {s, 8'hFF, 23'd0};
      3:       return {s, 8'hFF, 23'($urandom_range(1, 32'h7F_FFFF))};
      4:       return {s, 8'd0, 23'($urandom)};
      5:       return {s, 31'h7F7F_FFFF};
      6:       return $urandom;
      default: return {s, 8'($urandom_range(110, 140)), 23'($urandom)};
    endcase
  endfunction

  function automatic logic [31:0] random_element();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(0, 7))
      0:       w[14:10] = 5'd0;
      1:       w[14:10] = 5'h1F;
      2:       w[15:0]  = $urandom_range(0, 1) ? wwfd_pkg::LIN_FULL : 16'd0;
      default: ;
    endcase
    return w;
  endfunction

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset configuration: linear16 over a zero range.
    pending_words = '{32'h0000_0000, 32'h0000_8000, 32'hFFFF_FFFF};
    wait_idle();

    // Linear16 over [-1, 1]: range ends, midpoint, neighbors and ignored upper bits.
    set_format(wwfd_pkg::ENC_LINEAR16, 32'hBF80_0000, wwfd_pkg::ONE);
    pending_words = '{32'h0000_0000, 32'h0000_0001, 32'h0000_7FFF, 32'h0000_8000,
                      32'h0000_FFFE, 32'h0000_FFFF, 32'hABCD_1234};
    wait_idle();
    // A NaN range end, opposite infinities, subnormal ends and largest finite ends.
    set_format(wwfd_pkg::ENC_LINEAR16, 32'hFFC1_2345, wwfd_pkg::ONE);
    pending_words = '{32'h0000_0000, 32'h0000_4321};
    wait_idle();
    set_format(wwfd_pkg::ENC_LINEAR16, 32'hFF80_0000, 32'h7F80_0000);
    pending_words = '{32'h0000_0000, 32'h0000_8000, 32'h0000_FFFF};
    wait_idle();
    set_format(wwfd_pkg::ENC_LINEAR16, 32'h0000_0001, 32'h8000_0001);
    pending_words = '{32'h0000_0000, 32'h0000_8000, 32'h0000_FFFF};
    wait_idle();
    set_format(wwfd_pkg::ENC_LINEAR16, 32'hFF7F_FFFF, 32'h7F7F_FFFF);
    pending_words = '{32'h0000_0001, 32'h0000_7FFF, 32'h0000_FFFE};
    wait_idle();

    // Half: signed zeros, subnormals, largest finite, infinities and NaN payloads.
    set_format(wwfd_pkg::ENC_HALF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    pending_words = '{32'h0000_0000, 32'h0000_8000, 32'h0000_0001, 32'h0000_03FF,
                      32'h0000_0400, 32'h0000_7BFF, 32'h0000_7C00, 32'h0000_FC00,
                      32'h0000_7E01, 32'h0000_FC01, 32'hFFFF_3C00};
    wait_idle();
    write_reg(wwfd_pkg::REG_ENCODING, {30'd0, wwfd_pkg::ENC_BF16});
    pending_words = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h5555_1234};
    wait_idle();
    write_reg(wwfd_pkg::REG_ENCODING, {30'd0, wwfd_pkg::ENC_SINGLE});
    pending_words = '{32'hFFFF_FFFF, 32'h7F80_0001, 32'h0000_0000, 32'h8000_0000};
    wait_idle();

    // Random phases; the last one runs without idle bursts.
    for (int ph = 0; ph < 12; ph++) begin
      set_format(wwfd_pkg::enc_e'($urandom_range(0, 3)), random_range_bound(),
                 random_range_bound());
      if (ph == 11) quiet = 1'b1;
      for (int i = 0; i < 37; i++) pending_words.push_back(random_element());
      wait_idle();
    end

    if (expected_values.size() != 0) errors++;
    if (errors == 0) begin
      $display("** weight_word_to_float_decoder: PASSED **");
    end else begin
      $display("** weight_word_to_float_decoder: FAILED **");
    end
    $finish;
  end

endmodule

/* files.f */
design/wwfd_pkg.sv
design/weight_word_to_float_decoder.sv
tb/tb_weight_word_to_float_decoder.sv
